@@ hw/rtl/polar_vector_sum_assert.svh @@
// Assertion macros for the checker file.
`ifndef POLAR_VECTOR_SUM_ASSERT_SVH
`define POLAR_VECTOR_SUM_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PVS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define PVS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/pvs_pkg.sv @@
// ----------------------------------------------------------------------------
// pvs_pkg: shared constants and types for the polar vector sum.
// Widths, angle constants and the arctangent table used by both CORDICs.
// ----------------------------------------------------------------------------
`default_nettype none
package pvs_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN = 24;
	localparam int N_STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	// Datapath width: lengths in Q.20 plus gain and summing headroom.
	localparam int DW = 40;
	// Angle accumulator in degrees Q.16.
	localparam int ZW = 28;
	localparam int LEN_W = 16;
	localparam int ANG_W = 18;
	localparam int OLEN_W = 17;
	localparam int OANG_W = 17;
	localparam logic signed [ANG_W-1:0] DEG90 = 18'sd23040;
	localparam logic signed [ANG_W-1:0] DEG180 = 18'sd46080;
	localparam logic signed [ANG_W+1:0] DEG360 = 20'sd92160;
	localparam logic [31:0] INV_GAIN_SQ = 32'd1583795506;

	typedef logic signed [DW-1:0] dat_t;
	typedef logic signed [ZW-1:0] ang_t;

	function automatic ang_t atan_q16(input int i);
		ang_t r;
		case (i)
			0: r = 28'sd2949120;  1: r = 28'sd1740967;  2: r = 28'sd919879;
			3: r = 28'sd466945;   4: r = 28'sd234379;   5: r = 28'sd117266;
			6: r = 28'sd58666;    7: r = 28'sd29335;    8: r = 28'sd14668;
			9: r = 28'sd7334;     10: r = 28'sd3667;    11: r = 28'sd1833;
			12: r = 28'sd917;     13: r = 28'sd458;     14: r = 28'sd229;
			15: r = 28'sd115;     16: r = 28'sd57;      17: r = 28'sd29;
			18: r = 28'sd14;      19: r = 28'sd7;       20: r = 28'sd4;
			21: r = 28'sd2;       22: r = 28'sd1;       default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/pvs_rotate.sv @@
// ----------------------------------------------------------------------------
// pvs_rotate: pipelined rotation-mode CORDIC.
// Turns one vector (length, angle) into x and y parts, one micro-rotation per
// stage, with the whole-turn and half-turn folding in a front stage.
// ----------------------------------------------------------------------------
`default_nettype none
module pvs_rotate (
	input  wire                                  clk,
	input  wire                                  en,
	input  wire logic signed [pvs_pkg::LEN_W-1:0] len,
	input  wire logic signed [pvs_pkg::ANG_W-1:0] ang,
	output pvs_pkg::dat_t                        x,
	output pvs_pkg::dat_t                        y
);
	import pvs_pkg::*;

	logic signed [ANG_W+1:0] a_w, a_red;
	dat_t                    x0;
	ang_t                    z0;
	dat_t                    x_s [N_STEPS+1];
	dat_t                    y_s [N_STEPS+1];
	ang_t                    z_s [N_STEPS+1];

	// Reduce into (-180, 180] then fold into [-90, 90].
	always_comb begin
		a_w = (ANG_W+2)'(ang);
		a_red = a_w;
		if (a_w > 20'(DEG180)) begin
			a_red = a_w - DEG360;
		end else if (a_w <= -20'(DEG180)) begin
			a_red = a_w + DEG360;
		end
		x0 = DW'(len) <<< 12;
		if (a_red > 20'(DEG90)) begin
			x0 = -x0;
			a_red = a_red - 20'(DEG180);
		end else if (a_red < -20'(DEG90)) begin
			x0 = -x0;
			a_red = a_red + 20'(DEG180);
		end
		z0 = ZW'(a_red) <<< 8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= x0;
			y_s[0] <= '0;
			z_s[0] <= z0;
		end
	end

	for (genvar i = 0; i < N_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q16(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q16(i);
				end
			end
		end
	end

	assign x = x_s[N_STEPS];
	assign y = y_s[N_STEPS];
endmodule
`default_nettype wire

@@ hw/rtl/pvs_vector.sv @@
// ----------------------------------------------------------------------------
// pvs_vector: pipelined vectoring-mode CORDIC.
// Takes the summed parts and yields the gained magnitude and atan2 angle.
// ----------------------------------------------------------------------------
`default_nettype none
module pvs_vector (
	input  wire                clk,
	input  wire                en,
	input  wire pvs_pkg::dat_t x,
	input  wire pvs_pkg::dat_t y,
	output pvs_pkg::dat_t      mag,
	output pvs_pkg::ang_t      ang,
	output logic               zero
);
	import pvs_pkg::*;

	dat_t x_s [N_STEPS+1];
	dat_t y_s [N_STEPS+1];
	ang_t z_s [N_STEPS+1];
	logic zr_s [N_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			zr_s[0] <= (x == '0) && (y == '0);
			if (x[DW-1]) begin
				x_s[0] <= -x;
				y_s[0] <= -y;
				z_s[0] <= y[DW-1] ? -(ZW'(DEG180) <<< 8) : (ZW'(DEG180) <<< 8);
			end else begin
				x_s[0] <= x;
				y_s[0] <= y;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				zr_s[i+1] <= zr_s[i];
				if (!y_s[i][DW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q16(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q16(i);
				end
			end
		end
	end

	assign mag = x_s[N_STEPS];
	assign ang = z_s[N_STEPS];
	assign zero = zr_s[N_STEPS];
endmodule
`default_nettype wire

@@ hw/rtl/pvs_scale.sv @@
// ----------------------------------------------------------------------------
// pvs_scale: gain removal and output rounding.
// Two stages: multiply by the squared inverse gain, then round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module pvs_scale (
	input  wire                             clk,
	input  wire                             en,
	input  wire pvs_pkg::dat_t              mag,
	input  wire pvs_pkg::ang_t              ang,
	input  wire                             zero,
	output logic [pvs_pkg::OLEN_W-1:0]      len_o,
	output logic signed [pvs_pkg::OANG_W-1:0] ang_o
);
	import pvs_pkg::*;

	// Magnitude split in two 20-bit halves so each product stays narrow.
	logic [19:0]        m_lo, m_hi;
	logic [51:0]        p_lo_s1, p_hi_s1;
	ang_t               z_s1;
	logic               zr_s1;
	logic [72:0]        prod;
	logic [40:0]        m32;
	logic [29:0]        l_r;
	logic signed [ZW-1:0] a_r;

	assign m_lo = mag[DW-1] ? '0 : mag[19:0];
	assign m_hi = mag[DW-1] ? '0 : mag[39:20];

	always_ff @(posedge clk) begin
		if (en) begin
			p_lo_s1 <= 52'(m_lo) * 52'(INV_GAIN_SQ);
			p_hi_s1 <= 52'(m_hi) * 52'(INV_GAIN_SQ);
			z_s1 <= ang;
			zr_s1 <= zero;
		end
	end

	always_comb begin
		prod = 73'(p_lo_s1) + (73'(p_hi_s1) << 20);
		m32 = prod[72:32];
		l_r = 30'((42'(m32) + 42'd2048) >> 12);
		a_r = (z_s1 + ZW'(128)) >>> 8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zr_s1) begin
				len_o <= '0;
				ang_o <= '0;
			end else begin
				len_o <= (l_r > 30'd65536) ? OLEN_W'(65536) : l_r[OLEN_W-1:0];
				if (a_r > ZW'(DEG180)) ang_o <= OANG_W'(DEG180);
				else if (a_r < -ZW'(DEG180)) ang_o <= -OANG_W'(DEG180);
				else ang_o <= a_r[OANG_W-1:0];
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/polar_vector_sum.sv @@
// ----------------------------------------------------------------------------
// polar_vector_sum: sum of two polar vectors by pipelined CORDIC.
// Both vectors are rotated into x and y parts, added, and vectored back.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         first_length, first_angle, second_length, second_angle
// m_axis    out        sum_length, sum_angle
//
// One transaction may enter every cycle while m_axis is not stalled. The pipeline
// has one stage per micro-rotation in each CORDIC, plus a front stage in each
// CORDIC, the sum stage and two scaling stages.
// Reset clears only the valid bits; data registers carry no reset.
// A stall on m_axis freezes the whole pipeline; s_axis_tready is low whenever
// the output holds an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none
module polar_vector_sum (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] first_length, [33:16] first_angle, [49:34] second_length,
	// [67:50] second_angle, [71:68] zero
	input  wire  [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// [16:0] sum_length, [33:17] sum_angle, [39:34] zero
	output logic [39:0] m_axis_tdata
);
	import pvs_pkg::*;

	localparam int LAT = 2 * N_STEPS + 5;

	logic [LAT-1:0] vld_q;
	logic           en;
	dat_t           x1, y1, x2, y2, xs_q, ys_q, mag;
	ang_t           ang;
	logic           zero;
	logic [OLEN_W-1:0]        len_o;
	logic signed [OANG_W-1:0] ang_o;

	// The pipeline advances unless the last stage holds an untaken result.
	assign en = !(vld_q[LAT-1] && !m_axis_tready);
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	pvs_rotate u_rot1 (
		.clk(clk), .en(en),
		.len(s_axis_tdata[15:0]), .ang(s_axis_tdata[33:16]), .x(x1), .y(y1)
	);
	pvs_rotate u_rot2 (
		.clk(clk), .en(en),
		.len(s_axis_tdata[49:34]), .ang(s_axis_tdata[67:50]), .x(x2), .y(y2)
	);

	// Sum of the two parts, registered ahead of the vectoring CORDIC.
	always_ff @(posedge clk) begin
		if (en) begin
			xs_q <= x1 + x2;
			ys_q <= y1 + y2;
		end
	end

	pvs_vector u_vec (
		.clk(clk), .en(en), .x(xs_q), .y(ys_q), .mag(mag), .ang(ang), .zero(zero)
	);

	pvs_scale u_scale (
		.clk(clk), .en(en), .mag(mag), .ang(ang), .zero(zero),
		.len_o(len_o), .ang_o(ang_o)
	);

	assign m_axis_tvalid = vld_q[LAT-1];
	assign m_axis_tdata = {6'd0, ang_o, len_o};
endmodule
`default_nettype wire

@@ hw/rtl/pvs_checker.sv @@
// ----------------------------------------------------------------------------
// pvs_checker: port-level checks for the polar vector sum.
// Watches the two stream channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polar_vector_sum_assert.svh"
module pvs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_axis_tready,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [39:0] m_axis_tdata
);
	`PVS_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
	`PVS_ASSERT_IMP(a_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input blocked with free output")
	`PVS_ASSERT_IMP(a_len, m_axis_tvalid, m_axis_tdata[16:0] <= 17'd65536, "length out of range")
	`PVS_ASSERT_IMP(a_pad, m_axis_tvalid, m_axis_tdata[39:34] == 6'd0, "padding not zero")
endmodule
bind polar_vector_sum pvs_checker u_pvs_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

@@ test/polar_vector_sum_tb.sv @@
// ----------------------------------------------------------------------------
// polar_vector_sum_tb: self-checking bench for the polar vector sum.
// Vector pairs are driven in random bursts, and each sum read back is compared
// with the length and direction computed here by a bit-true CORDIC.
// ----------------------------------------------------------------------------
module polar_vector_sum_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pvs_pkg::*;

	localparam longint LIMIT = 400000;
	localparam int TAIL = 2 * CORDIC_STEPS + 20;

	// One vector pair as it enters the block.
	typedef struct packed {
		logic signed [17:0] ang2;
		logic signed [15:0] len2;
		logic signed [17:0] ang1;
		logic signed [15:0] len1;
	} pair_t;

	// One resultant as it leaves the block.
	typedef struct packed {
		logic [16:0] len;
		logic [16:0] ang;
	} sum_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	pair_t pending_pairs[$];
	sum_t expected_sums[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_off = 1'b0;
	bit gen_done = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;

	polar_vector_sum dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Arctangent of 2^-i in degrees Q.16, kept here independently of the RTL.
	function automatic longint atan_deg(input int i);
		longint t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117266, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4,
			2, 1, 0};
		return t[i];
	endfunction

	// Rotation CORDIC: Q8.8 length at a Q.8 angle into x and y parts in Q.20,
	// still carrying the CORDIC gain. Shifts floor, as >>> does on signed values.
	function automatic void rotate(input longint len, input longint ang,
			output longint px, output longint py);
		longint x, y, z, xs, ys;
		int steps;
		steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
		while (ang > 46080) ang -= 92160;
		while (ang <= -46080) ang += 92160;
		x = len * 4096;
		// Beyond a right angle the vector is flipped and turned half a circle.
		if (ang > 23040) begin
			x = -x;
			ang -= 46080;
		end else if (ang < -23040) begin
			x = -x;
			ang += 46080;
		end
		y = 0;
		z = ang * 256;
		for (int i = 0; i < steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_deg(i);
			end else begin
				x += ys; y -= xs; z += atan_deg(i);
			end
		end
		px = x;
		py = y;
	endfunction

	// Length and direction of the sum of both vectors of a pair.
	function automatic sum_t resultant(input pair_t p);
		longint x1, y1, x2, y2, x, y, z, xs, ys, a;
		logic [63:0] mag, ln;
		int steps;
		bit zero;
		sum_t r;
		steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
		rotate(longint'(p.len1), longint'(p.ang1), x1, y1);
		rotate(longint'(p.len2), longint'(p.ang2), x2, y2);
		x = x1 + x2;
		y = y1 + y2;
		zero = (x == 0 && y == 0);
		z = 0;
		// Left half plane: start from +-180 degrees; zero y counts as positive.
		if (x < 0) begin
			z = (y >= 0) ? 46080 * 256 : -46080 * 256;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < steps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_deg(i);
			end else begin
				x -= ys; y += xs; z -= atan_deg(i);
			end
		end
		mag = (x > 0) ? 64'(x) : 64'd0;
		mag = (mag * 64'd1583795506) >> 32;
		ln = (mag + 64'd2048) >> 12;
		if (ln > 65536) ln = 65536;
		a = (z + 128) >>> 8;
		if (a > 46080) a = 46080;
		if (a < -46080) a = -46080;
		if (zero) begin
			a = 0;
			ln = 0;
		end
		r.len = ln[16:0];
		r.ang = a[16:0];
		return r;
	endfunction

	function automatic pair_t make_pair(input longint l1, input longint a1,
			input longint l2, input longint a2);
		pair_t p;
		p.len1 = l1[15:0];
		p.ang1 = a1[17:0];
		p.len2 = l2[15:0];
		p.ang2 = a2[17:0];
		return p;
	endfunction

	// Angles stay within one full turn either way; the extremes are weighted.
	function automatic longint rand_angle();
		case ($urandom_range(0, 9))
			0: return 92160;
			1: return -92160;
			2: return longint'($urandom_range(0, 8)) * 11520;
			3: return -longint'($urandom_range(0, 8)) * 11520;
			default: return longint'($urandom_range(0, 184320)) - 92160;
		endcase
	endfunction

	function automatic longint rand_length();
		case ($urandom_range(0, 7))
			0: return 32767;
			1: return -32768;
			2: return longint'($urandom_range(0, 512)) - 256;
			default: return longint'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// Stimulus: directed corner cases first, then random pairs.
	initial begin
		longint l, a;
		pending_pairs.push_back(make_pair(0, 0, 0, 0));
		pending_pairs.push_back(make_pair(32767, 92160, 32767, -92160));
		pending_pairs.push_back(make_pair(-32768, -92160, -32768, 92160));
		pending_pairs.push_back(make_pair(32767, 0, 32767, 0));
		pending_pairs.push_back(make_pair(-32768, 0, -32768, 0));
		pending_pairs.push_back(make_pair(256, 46080, 256, 46080));
		pending_pairs.push_back(make_pair(256, -46080, 0, 0));
		pending_pairs.push_back(make_pair(256, 23040, 256, -23040));
		pending_pairs.push_back(make_pair(256, 23041, 256, -23041));
		pending_pairs.push_back(make_pair(256, 69120, 0, 0));
		pending_pairs.push_back(make_pair(256, -69120, 0, 0));
		pending_pairs.push_back(make_pair(256, 0, -256, 0));
		pending_pairs.push_back(make_pair(256, 0, 256, 46080));
		pending_pairs.push_back(make_pair(-256, 0, 0, 0));
		pending_pairs.push_back(make_pair(1, 131071, -1, -131072));
		pending_pairs.push_back(make_pair(32767, 23040, 32767, 23040));
		pending_pairs.push_back(make_pair(1000, 12345, -1000, 12345));
		pending_pairs.push_back(make_pair(32767, 11520, -32768, -34560));
		for (int i = 0; i < 1600; i++) begin
			if (i % 7 == 0) begin
				// Equal and opposite pair, so the sum is close to zero.
				l = rand_length();
				a = rand_angle();
				pending_pairs.push_back(make_pair(l, a, -l, a));
			end else if (i % 11 == 0) begin
				// Raw 18-bit angles, so every bit of the angle fields toggles.
				pending_pairs.push_back(make_pair(rand_length(),
					longint'($urandom_range(0, 262143)), rand_length(),
					longint'($urandom_range(0, 262143))));
			end else begin
				pending_pairs.push_back(make_pair(rand_length(), rand_angle(),
					rand_length(), rand_angle()));
			end
			// Once mid-run the sender holds back until the pipeline has drained.
			if (i == 800) begin
				wait (pending_pairs.size() == 0 && !s_axis_tvalid);
				hold_off = 1'b1;
				wait (expected_sums.size() == 0);
				hold_off = 1'b0;
			end
		end
		gen_done = 1'b1;
	end

	// Reset: asserted once at the start of the run.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		pair_t p;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_sums.push_back(resultant(pair_t'(s_axis_tdata[67:0])));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_pairs.size() > 0 && !hold_off) begin
					p = pending_pairs.pop_front();
					s_axis_tdata <= {4'b0, p};
					s_axis_tvalid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
					end
					burst_left--;
					if (burst_left == 0) begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each accepted result with the oldest expected sum, and
	// stall the output on a repeating pattern with random stretches.
	always @(posedge clk) begin
		sum_t got, want;
		cycles++;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = sum_t'({m_axis_tdata[16:0], m_axis_tdata[33:17]});
				if (expected_sums.size() == 0) begin
					$display("%0t: unexpected result len=%0d ang=%0d", $time,
						got.len, $signed(got.ang));
					errors++;
				end else begin
					want = expected_sums.pop_front();
					if (got.len !== want.len) begin
						$display("%0t: sum_length expected %0d actual %0d", $time,
							want.len, got.len);
						errors++;
					end
					if (got.ang !== want.ang) begin
						$display("%0t: sum_angle expected %0d actual %0d", $time,
							$signed(want.ang), $signed(got.ang));
						errors++;
					end
				end
			end
			stall_phase = (stall_phase + 1) % 64;
			if (stall_phase < 24) begin
				m_axis_tready <= 1'b1;
			end else if (stall_phase < 40) begin
				m_axis_tready <= ($urandom_range(0, 2) != 0);
			end else begin
				m_axis_tready <= ($urandom_range(0, 4) == 0);
			end
		end
	end

	// End of run: drain, let the pipeline settle, then report.
	initial begin
		fork
			begin
				wait (gen_done && pending_pairs.size() == 0 && !s_axis_tvalid
					&& expected_sums.size() == 0);
				repeat (TAIL) @(posedge clk);
			end
			begin
				wait (cycles >= LIMIT);
				$display("timeout after %0d cycles", cycles);
				errors++;
			end
		join_any
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/pvs_pkg.sv
hw/rtl/pvs_rotate.sv
hw/rtl/pvs_vector.sv
hw/rtl/pvs_scale.sv
hw/rtl/polar_vector_sum.sv
hw/rtl/pvs_checker.sv
test/polar_vector_sum_tb.sv
